// File: rtl/ackermann_steer_to_curvature_core_macros.svh
// Assertion macros for the steering-to-curvature core.
// Included by modules that check their own pipeline control; no dependencies.
`ifndef ACKERMANN_STEER_TO_CURVATURE_CORE_MACROS_SVH
`define ACKERMANN_STEER_TO_CURVATURE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: rtl/ackst_pkg.sv
// Shared types and constants for the steering-to-curvature core.
// No dependencies.
`timescale 1ns / 1ps
package ackst_pkg;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned CORDIC_STAGES = 30;
	localparam int unsigned ZW = 33;
	localparam int unsigned XYW = 34;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_STRAIGHT = 2'd1,
		ST_BAD_WB = 2'd2
	} status_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd843314857;
				5'd1: r = 32'd497837829;
				5'd2: r = 32'd263043837;
				5'd3: r = 32'd133525159;
				5'd4: r = 32'd67021687;
				5'd5: r = 32'd33543516;
				5'd6: r = 32'd16775851;
				5'd7: r = 32'd8388437;
				5'd8: r = 32'd4194283;
				5'd9: r = 32'd2097149;
				default: r = 32'd1 << (5'd30 - i);
			endcase
			return r;
		end
	endfunction
endpackage

// File: rtl/ackst_cordic_cell.sv
// One CORDIC rotation cell: rotates the vector by +/- atan(2^-I) and registers it.
// Depends on ackst_pkg.
`timescale 1ns / 1ps
module ackst_cordic_cell #(
	parameter int unsigned I = 0,
	parameter int unsigned SW = 8
) (
	input logic clk,
	input logic en,
	input logic signed [ackst_pkg::XYW-1:0] x_in,
	input logic signed [ackst_pkg::XYW-1:0] y_in,
	input logic signed [ackst_pkg::ZW-1:0] z_in,
	input logic [SW-1:0] side_in,
	output logic signed [ackst_pkg::XYW-1:0] x_s1,
	output logic signed [ackst_pkg::XYW-1:0] y_s1,
	output logic signed [ackst_pkg::ZW-1:0] z_s1,
	output logic [SW-1:0] side_s1
);
	logic signed [ackst_pkg::XYW-1:0] dx, dy;
	logic signed [ackst_pkg::ZW-1:0] at;
	assign dx = y_in >>> I;
	assign dy = x_in >>> I;
	assign at = $signed({1'b0, ackst_pkg::atan_q30(5'(I))});
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[ackst_pkg::ZW-1]) begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - at;
			end else begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + at;
			end
			side_s1 <= side_in;
		end
	end
endmodule

// File: rtl/ackst_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the remainder on.
// No package dependency.
`timescale 1ns / 1ps
module ackst_div_cell #(
	parameter int unsigned NW = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned QW = 8,
	parameter int unsigned SW = 8
) (
	input logic clk,
	input logic en,
	input logic [DW:0] rem_in,
	input logic [NW-1:0] num_in,
	input logic [DW-1:0] den_in,
	input logic [QW-1:0] quo_in,
	input logic [SW-1:0] side_in,
	output logic [DW:0] rem_s1,
	output logic [NW-1:0] num_s1,
	output logic [DW-1:0] den_s1,
	output logic [QW-1:0] quo_s1,
	output logic [SW-1:0] side_s1
);
	logic [DW+1:0] trial;
	logic [DW+1:0] sub;
	assign trial = {rem_in, num_in[NW-1]};
	assign sub = trial - {2'b00, den_in};
	always_ff @(posedge clk) begin
		if (en) begin
			if (!sub[DW+1]) begin
				rem_s1 <= sub[DW:0];
				quo_s1 <= {quo_in[QW-2:0], 1'b1};
			end else begin
				rem_s1 <= trial[DW:0];
				quo_s1 <= {quo_in[QW-2:0], 1'b0};
			end
			num_s1 <= {num_in[NW-2:0], 1'b0};
			den_s1 <= den_in;
			side_s1 <= side_in;
		end
	end
endmodule

// File: rtl/ackermann_steer_to_curvature_core.sv
// Steering angle to path curvature and turning radius, bicycle-model geometry.
// One request is accepted every cycle while the pipeline is not held; a result
// passes through 30 CORDIC cells plus three chains of divider cells (tangent 47,
// curvature 63, radius 36): 176 registered cell stages plus the output register.
// The whole pipeline advances together and holds when the output register is full
// and not taken. Depends on ackst_pkg, ackst_cordic_cell, ackst_div_cell and the
// macros header.
`timescale 1ns / 1ps
`include "ackermann_steer_to_curvature_core_macros.svh"
module ackermann_steer_to_curvature_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [17:0] steer_angle,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [19:0] wheelbase,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic signed [24:0] curvature,
	output logic signed [32:0] turning_radius
);
	localparam int unsigned FRAC_BITS = ackst_pkg::FRAC_BITS;
	localparam int unsigned NS = ackst_pkg::CORDIC_STAGES;
	localparam int unsigned XYW = ackst_pkg::XYW;
	localparam int unsigned ZW = ackst_pkg::ZW;
	// tangent divide: (y << F) / x, y,x < 2^31
	localparam int unsigned TNW = 31 + FRAC_BITS;
	localparam int unsigned TDW = 31;
	localparam int unsigned TQW = TNW;
	// curvature t<<F / L, capped
	localparam int unsigned CNW = TQW + FRAC_BITS;
	localparam int unsigned CDW = 20;
	localparam int unsigned RNW = 20 + FRAC_BITS;
	localparam int unsigned RDW = TQW;
	// side bits: valid, neg, bad, L
	localparam int unsigned SW = 3 + 20;
	localparam int unsigned LAT = NS + TNW + CNW + RNW;

	logic [19:0] wb_q;
	logic adv;
	logic [LAT-1:0] vld_q;
	logic ov_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wb_q <= 20'd65536;
		else if (cfg_valid) wb_q <= wheelbase;
	end

	assign adv = !ov_q || out_ready;
	assign in_ready = adv;

	// front end: magnitude and clamp
	logic neg;
	logic [17:0] mag;
	logic [17:0] lim;
	logic [17:0] amag;
	assign neg = steer_angle[17];
	assign mag = neg ? 18'(-steer_angle) : 18'(steer_angle);
	assign lim = 18'(ackst_pkg::PI_HALF_Q30 >> (30 - FRAC_BITS));
	assign amag = (mag > lim) ? lim : mag;

	logic signed [XYW-1:0] cx [NS+1];
	logic signed [XYW-1:0] cy [NS+1];
	logic signed [ZW-1:0] cz [NS+1];
	logic [SW-1:0] cs [NS+1];
	assign cx[0] = $signed({2'b00, ackst_pkg::CORDIC_GAIN_Q30});
	assign cy[0] = '0;
	assign cz[0] = $signed(ZW'({15'd0, amag} << (30 - FRAC_BITS)));
	assign cs[0] = {in_valid && adv, neg, wb_q == 20'd0, wb_q};

	for (genvar g = 0; g < NS; g++) begin : g_cordic
		ackst_cordic_cell #(.I(g), .SW(SW)) u_cell (
			.clk(clk), .en(adv),
			.x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .side_in(cs[g]),
			.x_s1(cx[g+1]), .y_s1(cy[g+1]), .z_s1(cz[g+1]), .side_s1(cs[g+1])
		);
	end

	// tangent divider chain; cosine is positive in range
	logic [TDW:0] tr [TNW+1];
	logic [TNW-1:0] tn [TNW+1];
	logic [TDW-1:0] td [TNW+1];
	logic [TQW-1:0] tq [TNW+1];
	logic [SW-1:0] ts [TNW+1];
	logic [30:0] ys;
	assign ys = cy[NS][XYW-1] ? 31'd0 : cy[NS][30:0];
	assign tr[0] = '0;
	assign tn[0] = TNW'({ys, {FRAC_BITS{1'b0}}});
	assign td[0] = cx[NS][30:0];
	assign tq[0] = '0;
	assign ts[0] = cs[NS];
	for (genvar g = 0; g < TNW; g++) begin : g_tdiv
		ackst_div_cell #(.NW(TNW), .DW(TDW), .QW(TQW), .SW(SW)) u_cell (
			.clk(clk), .en(adv), .rem_in(tr[g]), .num_in(tn[g]), .den_in(td[g]),
			.quo_in(tq[g]), .side_in(ts[g]), .rem_s1(tr[g+1]), .num_s1(tn[g+1]),
			.den_s1(td[g+1]), .quo_s1(tq[g+1]), .side_s1(ts[g+1])
		);
	end

	// curvature chain carries t alongside
	localparam int unsigned CSW = SW + TQW;
	logic [CDW:0] kr [CNW+1];
	logic [CNW-1:0] kn [CNW+1];
	logic [CDW-1:0] kd [CNW+1];
	logic [CNW-1:0] kq [CNW+1];
	logic [CSW-1:0] ks [CNW+1];
	logic [19:0] lden;
	assign lden = (ts[TNW][19:0] == 20'd0) ? 20'd1 : ts[TNW][19:0];
	assign kr[0] = '0;
	assign kn[0] = CNW'({tq[TNW], {FRAC_BITS{1'b0}}});
	assign kd[0] = lden;
	assign kq[0] = '0;
	assign ks[0] = {tq[TNW], ts[TNW]};
	for (genvar g = 0; g < CNW; g++) begin : g_cdiv
		ackst_div_cell #(.NW(CNW), .DW(CDW), .QW(CNW), .SW(CSW)) u_cell (
			.clk(clk), .en(adv), .rem_in(kr[g]), .num_in(kn[g]), .den_in(kd[g]),
			.quo_in(kq[g]), .side_in(ks[g]), .rem_s1(kr[g+1]), .num_s1(kn[g+1]),
			.den_s1(kd[g+1]), .quo_s1(kq[g+1]), .side_s1(ks[g+1])
		);
	end

	// radius chain: (L << F) / t, carries curvature
	localparam int unsigned RSW = SW + TQW + CNW;
	logic [RDW:0] rr [RNW+1];
	logic [RNW-1:0] rn [RNW+1];
	logic [RDW-1:0] rd [RNW+1];
	logic [RNW-1:0] rq [RNW+1];
	logic [RSW-1:0] rs [RNW+1];
	logic [TQW-1:0] tk;
	assign tk = ks[CNW][CSW-1:SW];
	assign rr[0] = '0;
	assign rn[0] = RNW'({ks[CNW][19:0], {FRAC_BITS{1'b0}}});
	assign rd[0] = (tk == '0) ? TQW'(1) : tk;
	assign rq[0] = '0;
	assign rs[0] = {kq[CNW], ks[CNW]};
	for (genvar g = 0; g < RNW; g++) begin : g_rdiv
		ackst_div_cell #(.NW(RNW), .DW(RDW), .QW(RNW), .SW(RSW)) u_cell (
			.clk(clk), .en(adv), .rem_in(rr[g]), .num_in(rn[g]), .den_in(rd[g]),
			.quo_in(rq[g]), .side_in(rs[g]), .rem_s1(rr[g+1]), .num_s1(rn[g+1]),
			.den_s1(rd[g+1]), .quo_s1(rq[g+1]), .side_s1(rs[g+1])
		);
	end

	// result formatting
	logic [RSW-1:0] fs;
	logic f_vld, f_neg, f_bad;
	logic [TQW-1:0] f_t;
	logic [CNW-1:0] f_c;
	logic [RNW-1:0] f_r;
	logic [1:0] st_d;
	logic [24:0] cv_d;
	logic [32:0] rd_d;
	logic [CNW:0] cmag;
	logic [RNW:0] rmag;
	assign fs = rs[RNW];
	assign f_vld = vld_q[LAT-1];
	assign f_neg = fs[SW-2];
	assign f_bad = fs[SW-3];
	assign f_t = fs[SW+TQW-1:SW];
	assign f_c = fs[RSW-1:SW+TQW];
	assign f_r = rq[RNW];
	always_comb begin
		cmag = {1'b0, f_c};
		rmag = {1'b0, f_r};
		if (f_neg) begin
			if (cmag > (CNW+1)'(25'd16777216)) cmag = (CNW+1)'(25'd16777216);
			if (rmag > (RNW+1)'(33'd4294967296)) rmag = (RNW+1)'(33'd4294967296);
			cv_d = 25'(-cmag);
			rd_d = 33'(-rmag);
		end else begin
			if (cmag > (CNW+1)'(25'd16777215)) cmag = (CNW+1)'(25'd16777215);
			if (rmag > (RNW+1)'(33'd4294967295)) rmag = (RNW+1)'(33'd4294967295);
			cv_d = 25'(cmag);
			rd_d = 33'(rmag);
		end
		st_d = ackst_pkg::ST_OK;
		if (f_bad) begin
			st_d = ackst_pkg::ST_BAD_WB;
			cv_d = '0;
			rd_d = '0;
		end else if (f_t == '0) begin
			st_d = ackst_pkg::ST_STRAIGHT;
			cv_d = '0;
			rd_d = 33'd4294967295;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= f_vld;
	end
	always_ff @(posedge clk) begin
		if (adv && f_vld) begin
			status <= st_d;
			curvature <= $signed(cv_d);
			turning_radius <= $signed(rd_d);
		end
	end
	assign out_valid = ov_q;

	// reset valid chain alongside the cells; it marks which stages hold a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status), "output lost during stall")
	`ASSERT_CLK(a_status_code, clk, arst_n, out_valid |-> (status != 2'd3),
		"undefined status")
	`ASSERT_CLK(a_bad_zero, clk, arst_n,
		(out_valid && status == ackst_pkg::ST_BAD_WB) |-> (curvature == 25'sd0),
		"bad wheelbase result not zero")
	`ASSERT_NEXT(a_fill, clk, arst_n, adv && vld_q[LAT-1], out_valid,
		"pipeline valid dropped")
endmodule
